/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`endif

/* rtl/core/kss_pkg.sv */
// ----------------------------------------------------------------------------
// kss_pkg
// Shared types and codes for the keyed sensor statistics table.
// ----------------------------------------------------------------------------
package kss_pkg;
   localparam logic [2:0] ST_UPDATED  = 3'd0;
   localparam logic [2:0] ST_NEW      = 3'd1;
   localparam logic [2:0] ST_REG_FULL = 3'd2;
   localparam logic [2:0] ST_TAB_FULL = 3'd3;
   localparam logic [2:0] ST_CLEARED  = 3'd4;
   localparam logic CSR_STATS_CAP  = 1'b0;
   localparam logic CSR_SENSOR_CAP = 1'b1;

   typedef struct packed {
      logic        start;
      logic [63:0] mag;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quot;
   } div_rsp_type;
endpackage

/* rtl/core/kss_ram.sv */
// ----------------------------------------------------------------------------
// kss_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module kss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

/* rtl/core/kss_div.sv */
// ----------------------------------------------------------------------------
// kss_div
// Restoring divider, one quotient bit per cycle: a 64-bit magnitude scaled
// by 256 divided by a 32-bit count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module kss_div (
   input  logic                 clock,
   input  logic                 reset,
   input  kss_pkg::div_req_type req,
   output kss_pkg::div_rsp_type rsp
);
   logic [71:0] quot_ff, quot_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[71]};
      if (req.start) begin
         quot_in = {req.mag, 8'd0};
         rem_in  = '0;
         dvs_in  = req.divisor;
         cnt_in  = 7'd72;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in  = trial[31:0] - dvs_ff;
            quot_in = {quot_ff[70:0], 1'b1};
         end else begin
            rem_in  = trial[31:0];
            quot_in = {quot_ff[70:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff[63:0];

   `ASSERT_NEVER(a_busy_done, clock, reset, busy_ff && done_ff, "divider busy and done")
   `ASSERT_CLK(a_done_after, clock, reset, done_ff |-> $past(busy_ff), "done without work")
   `ASSERT_NEVER(a_start_busy, clock, reset, req.start && busy_ff, "start while busy")
endmodule

/* rtl/core/keyed_sensor_statistics_table.sv */
// ----------------------------------------------------------------------------
// keyed_sensor_statistics_table
// Per-key running last/min/max/mean/count table with a sensor id registry.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy low; busy then stays high
// until the single result strobes on rsp_valid for one cycle, which the
// receiver must take; the next item can be taken in that strobe cycle.
// A clear goes from idle straight to the result state. A reading searches
// the registry and then the key table, each one RAM word at a time with a
// read state and a compare state, and the mean uses a bit-serial divider.
// A refused reading skips the divide and returns sooner.
`include "assert_macros.svh"
module keyed_sensor_statistics_table #(
   parameter int TABLE_ENTRIES    = 64,
   parameter int REGISTRY_ENTRIES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_cmd,
   input  logic [15:0]        req_sensor_id,
   input  logic [15:0]        req_key_id,
   input  logic signed [31:0] req_sample,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic [5:0]         rsp_entry_index,
   output logic signed [31:0] rsp_last_value,
   output logic signed [31:0] rsp_min_value,
   output logic signed [31:0] rsp_max_value,
   output logic signed [39:0] rsp_mean_q8,
   output logic [31:0]        rsp_sample_count,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [6:0]         csr_wdata
);
   localparam int TW = $clog2(TABLE_ENTRIES);
   localparam int RW = $clog2(REGISTRY_ENTRIES);
   localparam int TC = TW + 1;
   localparam int RC = RW + 1;

   localparam logic [3:0] S_IDLE = 4'd0, S_RREAD = 4'd1, S_RCMP = 4'd2,
      S_KREAD = 4'd3, S_KCMP = 4'd4, S_EREAD = 4'd5, S_EUPD = 4'd6,
      S_DIV = 4'd7, S_DWAIT = 4'd8, S_OUT = 4'd9;

   logic [3:0]  state_ff, state_in;
   logic [6:0]  scap_ff, rcap_ff;
   logic [RC-1:0] scount_ff, scount_in;
   logic [TC-1:0] etotal_ff, etotal_in;
   logic [RC-1:0] ri_ff, ri_in;
   logic [TC-1:0] ki_ff, ki_in;
   logic [15:0] sid_ff, key_ff;
   logic signed [31:0] val_ff;
   logic [2:0]  st_ff, st_in;
   logic        vld_ff, vld_in;
   logic signed [31:0] last_ff, last_in, min_ff, min_in, max_ff, max_in;
   logic signed [63:0] sum_ff, sum_in;
   logic [31:0] cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic [39:0] mean_ff, mean_in;

   logic          reg_we;
   logic [RW-1:0] reg_addr;
   logic [15:0]   reg_rd;
   logic          tab_we;
   logic [TW-1:0] tab_addr;
   logic [207:0]  tab_wd, tab_rd;
   kss_pkg::div_req_type dreq;
   kss_pkg::div_rsp_type drsp;

   logic [RC-1:0] rcap_eff;
   logic [TC-1:0] scap_eff;
   logic [63:0]   mag;
   logic [39:0]   mq;

   assign rcap_eff = (32'(rcap_ff) < 32'(REGISTRY_ENTRIES)) ? RC'(rcap_ff)
                   : RC'(REGISTRY_ENTRIES);
   assign scap_eff = (32'(scap_ff) < 32'(TABLE_ENTRIES)) ? TC'(scap_ff)
                   : TC'(TABLE_ENTRIES);
   assign mag = sum_ff[63] ? (64'd0 - sum_ff) : sum_ff;
   assign mq  = drsp.quot[39:0];

   kss_ram #(.WIDTH(16), .DEPTH(REGISTRY_ENTRIES)) u_reg (
      .clock(clock), .we(reg_we), .addr(reg_addr), .wdata(sid_ff), .rdata(reg_rd));
   kss_ram #(.WIDTH(208), .DEPTH(TABLE_ENTRIES)) u_tab (
      .clock(clock), .we(tab_we), .addr(tab_addr), .wdata(tab_wd), .rdata(tab_rd));
   kss_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign tab_wd = {key_ff, last_ff, min_ff, max_ff, sum_ff, cnt_ff};

   always_comb begin
      state_in  = state_ff;
      scount_in = scount_ff;
      etotal_in = etotal_ff;
      ri_in = ri_ff;
      ki_in = ki_ff;
      st_in = st_ff;
      vld_in = 1'b0;
      last_in = last_ff; min_in = min_ff; max_in = max_ff;
      sum_in = sum_ff; cnt_in = cnt_ff; neg_in = neg_ff; mean_in = mean_ff;
      reg_we = 1'b0; reg_addr = ri_ff[RW-1:0];
      tab_we = 1'b0; tab_addr = ki_ff[TW-1:0];
      dreq.start = 1'b0; dreq.mag = mag; dreq.divisor = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ri_in = '0;
               ki_in = '0;
               if (req_cmd) begin
                  scount_in = '0;
                  etotal_in = '0;
                  st_in = kss_pkg::ST_CLEARED;
                  state_in = S_OUT;
               end else begin
                  state_in = S_RREAD;
               end
            end
         end
         S_RREAD: begin
            if (ri_ff >= scount_ff) begin
               if (scount_ff >= rcap_eff) begin
                  st_in = kss_pkg::ST_REG_FULL;
                  state_in = S_OUT;
               end else begin
                  reg_addr = scount_ff[RW-1:0];
                  reg_we = 1'b1;
                  scount_in = scount_ff + 1'b1;
                  state_in = S_KREAD;
               end
            end else begin
               state_in = S_RCMP;
            end
         end
         S_RCMP: begin
            if (reg_rd == sid_ff) state_in = S_KREAD;
            else begin
               ri_in = ri_ff + 1'b1;
               state_in = S_RREAD;
            end
         end
         S_KREAD: begin
            if (ki_ff >= etotal_ff) begin
               if (etotal_ff >= scap_eff) begin
                  st_in = kss_pkg::ST_TAB_FULL;
                  state_in = S_OUT;
               end else begin
                  last_in = val_ff; min_in = val_ff; max_in = val_ff;
                  sum_in = 64'(val_ff); cnt_in = 32'd1;
                  st_in = kss_pkg::ST_NEW;
                  etotal_in = etotal_ff + 1'b1;
                  state_in = S_EUPD;
               end
            end else begin
               state_in = S_KCMP;
            end
         end
         S_KCMP: begin
            if (tab_rd[207:192] == key_ff) begin
               st_in = kss_pkg::ST_UPDATED;
               last_in = val_ff;
               min_in = (val_ff < $signed(tab_rd[159:128])) ? val_ff : $signed(tab_rd[159:128]);
               max_in = (val_ff > $signed(tab_rd[127:96])) ? val_ff : $signed(tab_rd[127:96]);
               if (tab_rd[31:0] != 32'hFFFF_FFFF) begin
                  sum_in = $signed(tab_rd[95:32]) + 64'(val_ff);
                  cnt_in = tab_rd[31:0] + 32'd1;
               end else begin
                  sum_in = $signed(tab_rd[95:32]);
                  cnt_in = tab_rd[31:0];
               end
               state_in = S_EUPD;
            end else begin
               ki_in = ki_ff + 1'b1;
               state_in = S_KREAD;
            end
         end
         S_EREAD: state_in = S_EUPD;
         S_EUPD: begin
            tab_we = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            dreq.start = 1'b1;
            neg_in = sum_ff[63];
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (drsp.done) begin
               mean_in = neg_ff ? (40'd0 - mq) : mq;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            vld_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         scount_ff <= '0;
         etotal_ff <= '0;
         scap_ff   <= 7'd64;
         rcap_ff   <= 7'd64;
         vld_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         scount_ff <= scount_in;
         etotal_ff <= etotal_in;
         vld_ff    <= vld_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == kss_pkg::CSR_STATS_CAP) scap_ff <= csr_wdata;
            else rcap_ff <= csr_wdata;
         end
      end
      if (state_ff == S_IDLE && start) begin
         sid_ff <= req_sensor_id;
         key_ff <= req_key_id;
         val_ff <= req_sample;
      end
      ri_ff <= ri_in; ki_ff <= ki_in; st_ff <= st_in;
      last_ff <= last_in; min_ff <= min_in; max_ff <= max_in;
      sum_ff <= sum_in; cnt_ff <= cnt_in; neg_ff <= neg_in; mean_ff <= mean_in;
   end

   logic ok;
   assign ok = (st_ff == kss_pkg::ST_UPDATED) || (st_ff == kss_pkg::ST_NEW);
   assign busy = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = vld_ff;
   assign rsp_status = st_ff;
   assign rsp_entry_index = ok ? 6'(ki_ff) : 6'd0;
   assign rsp_last_value = ok ? last_ff : 32'sd0;
   assign rsp_min_value = ok ? min_ff : 32'sd0;
   assign rsp_max_value = ok ? max_ff : 32'sd0;
   assign rsp_mean_q8 = ok ? mean_ff : 40'sd0;
   assign rsp_sample_count = ok ? cnt_ff : 32'd0;

   `ASSERT_CLK(a_rsp_idle, clock, reset, rsp_valid |-> !busy, "result while busy")
   `ASSERT_CLK(a_cnt_cap, clock, reset, scount_ff <= RC'(REGISTRY_ENTRIES), "registry overflow")
   `ASSERT_CLK(a_tot_cap, clock, reset, etotal_ff <= TC'(TABLE_ENTRIES), "table overflow")
endmodule
